FILE: rtl/tbdk_pkg.sv
// ----------------------------------------------------------------------------
// tbdk_pkg
// shared widths, register indexes and status types for the decay block
// ----------------------------------------------------------------------------
package tbdk_pkg;

  localparam int Q_W        = 24;  // q value
  localparam int E_W        = 38;  // rest masses
  localparam int R_W        = 16;  // random fractions
  localparam int D_W        = 16;  // direction components
  localparam int P_W        = 30;  // momentum result
  localparam int K_W        = 24;  // kinetic energies
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = E_W;

  localparam logic [CFG_IDX_W-1:0] REG_Q_VALUE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUCLEUS_MASS = 2'd2;

  typedef struct packed {
    logic [P_W-1:0] cm_momentum;
    logic [K_W-1:0] alpha_energy;
    logic [K_W-1:0] recoil_energy;
  } kin_res_t;

  typedef struct packed {
    logic     busy;
    kin_res_t res;
  } kin_stat_t;

endpackage

FILE: rtl/tbdk_kin.sv
// ----------------------------------------------------------------------------
// tbdk_kin
// configuration registers and the bit-serial momentum / energy sequencer
// ----------------------------------------------------------------------------
module tbdk_kin (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbdk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbdk_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tbdk_pkg::kin_stat_t                 stat
);

  typedef enum logic [3:0] {
    K_IDLE, K_START, K_M1, K_M2, K_M3, K_M4, K_DIV,
    K_SQP, K_M5, K_M6, K_SQA, K_M7, K_SQN
  } kin_state_t;

  kin_state_t state;

  logic [tbdk_pkg::Q_W-1:0] q_value;
  logic [tbdk_pkg::E_W-1:0] alpha_mass;
  logic [tbdk_pkg::E_W-1:0] nucleus_mass;

  logic [147:0] acc;
  logic [147:0] mcand;
  logic [82:0]  mplier;
  logic [64:0]  t1;
  logic [147:0] dvd;
  logic [81:0]  dsr;
  logic [82:0]  rem;
  logic [7:0]   cnt;
  logic [83:0]  rad;
  logic [41:0]  root;
  logic [44:0]  srem;
  logic [63:0]  psq;
  logic [41:0]  pres;
  logic [tbdk_pkg::P_W-1:0] pout;
  logic [tbdk_pkg::K_W-1:0] kea;
  logic [tbdk_pkg::K_W-1:0] ken;

  logic         cfg_hit;
  logic [40:0]  a_sum;
  logic [40:0]  b_sum;
  logic [41:0]  c_sum;
  logic [39:0]  m_sum;
  logic         mul_done;
  logic [147:0] acc_add;
  logic [82:0]  div_pre;
  logic         div_ge;
  logic [44:0]  sq_pre;
  logic [44:0]  sq_trial;
  logic         sq_ge;
  logic [41:0]  root_step;

  function automatic logic [tbdk_pkg::K_W-1:0] ke_sat(input logic [41:0] s,
                                                      input logic [tbdk_pkg::E_W-1:0] m);
    logic [41:0] d;
    d = s - 42'(m);
    if (d > 42'({tbdk_pkg::K_W{1'b1}})) return '1;
    return d[tbdk_pkg::K_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == tbdk_pkg::REG_Q_VALUE ||
                                   cfg_index == tbdk_pkg::REG_ALPHA_MASS ||
                                   cfg_index == tbdk_pkg::REG_NUCLEUS_MASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_value      <= '0;
      alpha_mass   <= '0;
      nucleus_mass <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbdk_pkg::REG_Q_VALUE:      q_value      <= cfg_data[tbdk_pkg::Q_W-1:0];
        tbdk_pkg::REG_ALPHA_MASS:   alpha_mass   <= cfg_data;
        tbdk_pkg::REG_NUCLEUS_MASS: nucleus_mass <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand sums of the two-body formula
  assign a_sum = 41'(q_value) + (41'(alpha_mass) << 1);
  assign b_sum = 41'(q_value) + (41'(nucleus_mass) << 1);
  assign c_sum = 42'(q_value) + (42'(alpha_mass) << 1) + (42'(nucleus_mass) << 1);
  assign m_sum = 40'(q_value) + 40'(alpha_mass) + 40'(nucleus_mass);

  // shift-add multiplier step
  assign mul_done = (mplier == '0);
  assign acc_add  = mplier[0] ? acc + mcand : acc;

  // restoring divider step
  assign div_pre = {rem[81:0], dvd[147]};
  assign div_ge  = (div_pre >= {1'b0, dsr});

  // digit-by-digit square root step
  assign sq_pre    = {srem[42:0], rad[83:82]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_ge     = (sq_pre >= sq_trial);
  assign root_step = {root[40:0], sq_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= K_IDLE;
      pout  <= '0;
      kea   <= '0;
      ken   <= '0;
    end else if (cfg_hit) begin
      state <= K_START;
    end else begin
      case (state)
        K_IDLE: ;
        K_START: begin
          acc    <= '0;
          mcand  <= 148'(q_value);
          mplier <= 83'(a_sum);
          state  <= K_M1;
        end
        K_M1: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            t1     <= acc[64:0];
            acc    <= '0;
            mcand  <= 148'(b_sum);
            mplier <= 83'(c_sum);
            state  <= K_M2;
          end
        end
        K_M2: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            acc    <= '0;
            mcand  <= acc;
            mplier <= 83'(t1);
            state  <= K_M3;
          end
        end
        K_M3: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            dvd    <= acc;
            acc    <= '0;
            mcand  <= 148'(m_sum);
            mplier <= 83'(m_sum);
            state  <= K_M4;
          end
        end
        K_M4: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            dsr <= {acc[79:0], 2'b00};
            rem <= '0;
            cnt <= 8'd148;
            if (m_sum == '0) begin
              // nothing to share: momentum is zero
              pres   <= '0;
              acc    <= '0;
              mcand  <= '0;
              mplier <= '0;
              state  <= K_M5;
            end else begin
              state <= K_DIV;
            end
          end
        end
        K_DIV: begin
          if (cnt != '0) begin
            rem <= div_ge ? div_pre - {1'b0, dsr} : div_pre;
            dvd <= {dvd[146:0], div_ge};
            cnt <= cnt - 8'd1;
          end else begin
            rad   <= dvd[83:0];
            root  <= '0;
            srem  <= '0;
            cnt   <= 8'd42;
            state <= K_SQP;
          end
        end
        K_SQP, K_SQA, K_SQN: begin
          if (cnt != '0) begin
            srem <= sq_ge ? sq_pre - sq_trial : sq_pre;
            root <= root_step;
            rad  <= rad << 2;
            cnt  <= cnt - 8'd1;
          end else begin
            acc <= '0;
            case (state)
              K_SQP: begin
                pres   <= root;
                mcand  <= 148'(root);
                mplier <= 83'(root);
                state  <= K_M5;
              end
              K_SQA: begin
                kea    <= ke_sat(root, alpha_mass);
                mcand  <= 148'(nucleus_mass);
                mplier <= 83'(nucleus_mass);
                state  <= K_M7;
              end
              default: begin
                ken   <= ke_sat(root, nucleus_mass);
                pout  <= (pres > 42'({tbdk_pkg::P_W{1'b1}})) ? '1 :
                         pres[tbdk_pkg::P_W-1:0];
                state <= K_IDLE;
              end
            endcase
          end
        end
        K_M5: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            psq    <= acc[63:0];
            acc    <= '0;
            mcand  <= 148'(alpha_mass);
            mplier <= 83'(alpha_mass);
            state  <= K_M6;
          end
        end
        K_M6, K_M7: begin
          if (!mul_done) begin
            acc <= acc_add; mcand <= mcand << 1; mplier <= mplier >> 1;
          end else begin
            rad   <= 84'(psq) + acc[83:0];
            root  <= '0;
            srem  <= '0;
            cnt   <= 8'd42;
            state <= (state == K_M6) ? K_SQA : K_SQN;
          end
        end
        default: state <= K_IDLE;
      endcase
    end
  end

  assign stat.busy              = (state != K_IDLE);
  assign stat.res.cm_momentum   = pout;
  assign stat.res.alpha_energy  = kea;
  assign stat.res.recoil_energy = ken;

endmodule

FILE: rtl/tbdk_dir.sv
// ----------------------------------------------------------------------------
// tbdk_dir
// pipelined isotropic direction: cos theta, sin theta root, sin/cos of phi
// ----------------------------------------------------------------------------
module tbdk_dir (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [tbdk_pkg::R_W-1:0]            rand_polar,
  input  logic [tbdk_pkg::R_W-1:0]            rand_azimuth,
  output logic                                ready,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_x,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_y,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_z
);

  localparam int NST = 18;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
  localparam int SIN_SH  [6] = '{8, 7, 7, 6, 5, 3};
  localparam int COS_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};
  localparam int COS_SH  [7] = '{8, 8, 7, 6, 5, 4, 1};

  // exact reciprocals: floor(n / k) = (n * m) >> (32 + sh) for n below 2^32
  localparam logic [32:0] SIN_RCP [6] = '{
    33'(((66'd1 << (32 + SIN_SH[0])) + 66'(SIN_DIV[0]) - 66'd1) / 66'(SIN_DIV[0])),
    33'(((66'd1 << (32 + SIN_SH[1])) + 66'(SIN_DIV[1]) - 66'd1) / 66'(SIN_DIV[1])),
    33'(((66'd1 << (32 + SIN_SH[2])) + 66'(SIN_DIV[2]) - 66'd1) / 66'(SIN_DIV[2])),
    33'(((66'd1 << (32 + SIN_SH[3])) + 66'(SIN_DIV[3]) - 66'd1) / 66'(SIN_DIV[3])),
    33'(((66'd1 << (32 + SIN_SH[4])) + 66'(SIN_DIV[4]) - 66'd1) / 66'(SIN_DIV[4])),
    33'(((66'd1 << (32 + SIN_SH[5])) + 66'(SIN_DIV[5]) - 66'd1) / 66'(SIN_DIV[5]))
  };
  localparam logic [32:0] COS_RCP [7] = '{
    33'(((66'd1 << (32 + COS_SH[0])) + 66'(COS_DIV[0]) - 66'd1) / 66'(COS_DIV[0])),
    33'(((66'd1 << (32 + COS_SH[1])) + 66'(COS_DIV[1]) - 66'd1) / 66'(COS_DIV[1])),
    33'(((66'd1 << (32 + COS_SH[2])) + 66'(COS_DIV[2]) - 66'd1) / 66'(COS_DIV[2])),
    33'(((66'd1 << (32 + COS_SH[3])) + 66'(COS_DIV[3]) - 66'd1) / 66'(COS_DIV[3])),
    33'(((66'd1 << (32 + COS_SH[4])) + 66'(COS_DIV[4]) - 66'd1) / 66'(COS_DIV[4])),
    33'(((66'd1 << (32 + COS_SH[5])) + 66'(COS_DIV[5]) - 66'd1) / 66'(COS_DIV[5])),
    33'(((66'd1 << (32 + COS_SH[6])) + 66'(COS_DIV[6]) - 66'd1) / 66'(COS_DIV[6]))
  };

  typedef struct packed {
    logic signed [15:0] cos_t;
    logic [1:0]         quad;
    logic [60:0]        xp;
    logic [30:0]        x;
    logic [61:0]        x2p;
    logic [31:0]        x2;
    logic [62:0]        ps;
    logic [62:0]        pc;
    logic [64:0]        qs;
    logic [64:0]        qc;
    logic [61:0]        sp;
    logic [31:0]        srad;
    logic [15:0]        sroot;
    logic [17:0]        srem;
    logic signed [31:0] co;
    logic signed [31:0] si;
    logic [46:0]        mx;
    logic [46:0]        my;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } st_t;

  function automatic st_t first(input logic [15:0] rp, input logic [15:0] ra);
    st_t s;
    logic signed [31:0] c32;
    logic signed [31:0] sq;
    s       = '0;
    s.cos_t = {~rp[15], rp[14:0]};
    c32     = 32'(s.cos_t);
    sq      = c32 * c32;
    s.srad  = 32'h4000_0000 - 32'(sq);
    s.quad  = ra[15:14];
    s.xp    = 61'({ra[13:0], 16'd0}) * 61'(HALF_PI_Q30);
    return s;
  endfunction

  function automatic logic signed [15:0] round_sat(input logic neg, input logic [46:0] m);
    logic [46:0] r;
    r = (m + 47'(1 << 29)) >> 30;
    if (neg) begin
      if (r > 47'd32768) return 16'sh8000;
      return 16'(-r);
    end
    if (r > 47'd32767) return 16'sh7fff;
    return 16'(r);
  endfunction

  function automatic st_t step(input int k, input st_t a);
    st_t s;
    int j;
    int i;
    int im1;
    logic [19:0] pre;
    logic [19:0] trial;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [32:0] qcv;
    logic signed [33:0] tcs;
    logic [30:0] cval;
    logic [30:0] sval;
    logic [30:0] mco;
    logic [30:0] msi;
    s   = a;
    j   = k - 2;
    i   = j / 2;
    im1 = (i == 0) ? 0 : i - 1;
    // sin theta root, four digits a stage
    if (k >= 1 && k <= 4) begin
      for (int n = 0; n < 4; n++) begin
        pre   = {s.srem, s.srad[31:30]};
        trial = {2'b00, s.sroot, 2'b01};
        if (pre >= trial) begin
          s.srem  = 18'(pre - trial);
          s.sroot = {s.sroot[14:0], 1'b1};
        end else begin
          s.srem  = pre[17:0];
          s.sroot = {s.sroot[14:0], 1'b0};
        end
        s.srad = s.srad << 2;
      end
    end
    if (k == 1) begin
      s.x   = a.xp[60:30];
      s.x2p = 62'(s.x) * 62'(s.x);
    end
    if (k == 2) s.x2 = a.x2p[61:30];
    // taylor polynomials, one multiply then one reciprocal multiply per term
    if (k >= 2 && k <= 15) begin
      if (j % 2 == 0) begin
        if (i < 6) begin
          ts   = (i == 0) ? ONE_Q30 :
                 31'(65'(ONE_Q30) - (a.qs >> (32 + SIN_SH[im1])));
          s.ps = 63'(s.x2) * 63'(ts);
        end else begin
          ts   = 31'(65'(ONE_Q30) - (a.qs >> (32 + SIN_SH[5])));
          s.sp = 62'(s.x) * 62'(ts);
        end
        tc   = (i == 0) ? ONE_Q30 :
               31'(65'(ONE_Q30) - (a.qc >> (32 + COS_SH[im1])));
        s.pc = 63'(s.x2) * 63'(tc);
      end else begin
        if (i < 6) s.qs = 65'(a.ps[62:30]) * 65'(SIN_RCP[i]);
        s.qc = 65'(a.pc[62:30]) * 65'(COS_RCP[i]);
      end
    end
    // clamp, unfold the quadrant, scale by sin theta
    if (k == 16) begin
      qcv  = 33'(a.qc >> (32 + COS_SH[6]));
      tcs  = $signed({3'b000, ONE_Q30}) - $signed({1'b0, qcv});
      if (tcs < 0)                             cval = '0;
      else if (tcs > $signed({3'b000, ONE_Q30})) cval = ONE_Q30;
      else                                     cval = tcs[30:0];
      sval = (a.sp[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : a.sp[60:30];
      case (a.quad)
        2'd0:    begin s.co =  32'(cval); s.si =  32'(sval); end
        2'd1:    begin s.co = -32'(sval); s.si =  32'(cval); end
        2'd2:    begin s.co = -32'(cval); s.si = -32'(sval); end
        default: begin s.co =  32'(sval); s.si = -32'(cval); end
      endcase
      mco  = (a.quad == 2'd0 || a.quad == 2'd2) ? cval : sval;
      msi  = (a.quad == 2'd0 || a.quad == 2'd2) ? sval : cval;
      s.mx = 47'(mco) * 47'(a.sroot);
      s.my = 47'(msi) * 47'(a.sroot);
    end
    if (k == 17) begin
      s.dx = round_sat(a.co < 0, a.mx);
      s.dy = round_sat(a.si < 0, a.my);
    end
    return s;
  endfunction

  st_t              stq [NST];
  logic [NST-1:0]   v;
  logic [NST:0]     en;

  assign en[NST] = !out_stall;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    assign en[k] = !v[k] || en[k+1];
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) v[0] <= 1'b0;
        else if (en[0]) v[0] <= take;
      end
      always_ff @(posedge clk) begin
        if (en[0]) stq[0] <= first(rand_polar, rand_azimuth);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (rst) v[k] <= 1'b0;
        else if (en[k]) v[k] <= v[k-1];
      end
      always_ff @(posedge clk) begin
        if (en[k]) stq[k] <= step(k, stq[k-1]);
      end
    end
  end

  assign ready     = en[0];
  assign out_valid = v[NST-1];
  assign dir_x     = stq[NST-1].dx;
  assign dir_y     = stq[NST-1].dy;
  assign dir_z     = stq[NST-1].cos_t;

endmodule

FILE: rtl/two_body_decay_kinematics.sv
// ----------------------------------------------------------------------------
// two_body_decay_kinematics
// alpha decay at rest: cm momentum, kinetic energies, isotropic direction
// ----------------------------------------------------------------------------
// usage
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes q value,
//   alpha mass and daughter mass; cfg_ready is always high
// - each register write restarts a bit-serial sequencer that works out the
//   momentum and both kinetic energies; these depend only on the registers,
//   so they are computed once and attached to every result word
// - the sequencer runs seven shift-add multiplies and at most a 148-step divide
//   and three 42-step roots; in_stall stays high meanwhile
// - input channel (in_valid/in_stall) takes one word of two random fractions
//   per cycle once the sequencer is idle, no write is pending and the pipeline has room
// - direction path is an 18-stage pipeline, one word per cycle while the output
//   is not stalled
// - output channel (out_valid/out_stall): on a stall the last stage holds and
//   bubbles ahead of it still close up, so input keeps flowing until full
// - reset clears the config, state, valid and result registers to zero, which gives zero momentum and energy
// ----------------------------------------------------------------------------
module two_body_decay_kinematics (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbdk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbdk_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tbdk_pkg::R_W-1:0]            rand_polar,
  input  logic [tbdk_pkg::R_W-1:0]            rand_azimuth,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_x,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_y,
  output logic signed [tbdk_pkg::D_W-1:0]     dir_z,
  output logic [tbdk_pkg::P_W-1:0]            cm_momentum,
  output logic [tbdk_pkg::K_W-1:0]            alpha_energy,
  output logic [tbdk_pkg::K_W-1:0]            recoil_energy
);

  tbdk_pkg::kin_stat_t kst;
  logic                dir_ready;
  logic                take;

  // momentum and energy sequencer, restarted by every register write
  tbdk_kin u_kin (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (kst)
  );

  // hold input while the pipeline is full, the kinematics are stale or a write is in progress
  assign in_stall = !dir_ready || kst.busy || cfg_valid;
  assign take     = in_valid && !in_stall;

  tbdk_dir u_dir (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rand_polar   (rand_polar),
    .rand_azimuth (rand_azimuth),
    .ready        (dir_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z)
  );

  // kinematics come straight from the sequencer registers; a write can change them while words are in flight
  assign cm_momentum   = kst.res.cm_momentum;
  assign alpha_energy  = kst.res.alpha_energy;
  assign recoil_energy = kst.res.recoil_energy;

  // a register write blocks input on the following cycle
  a_write_blocks: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == tbdk_pkg::REG_Q_VALUE ||
                                cfg_index == tbdk_pkg::REG_ALPHA_MASS ||
                                cfg_index == tbdk_pkg::REG_NUCLEUS_MASS))
    |=> in_stall)
    else $error("input not held after register write");

  // the sequencer only starts because of a write
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(kst.busy) |-> $past(cfg_valid && cfg_ready))
    else $error("sequencer started without a register write");

endmodule
